### hw/rtl/oafb_pkg.sv
// Package: types, constants and CRC step for the object access frame builder
`timescale 1ns / 1ps
`default_nettype none
package oafb_pkg;

    localparam logic [7:0] MARK_DLE  = 8'h90;
    localparam logic [7:0] MARK_STX  = 8'h02;
    localparam logic [7:0] OP_READ   = 8'h60;
    localparam logic [7:0] OP_WRITE  = 8'h68;
    localparam logic [7:0] LEN_READ  = 8'h02;
    localparam logic [7:0] LEN_WRITE = 8'h04;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] NODE_ID_RESET   = 8'h01;
    localparam logic [7:0] SUB_INDEX_RESET = 8'h00;

    localparam logic REG_NODE_ID   = 1'b0;
    localparam logic REG_SUB_INDEX = 1'b1;

    localparam int PAYLOAD_MAX = 10;
    localparam logic [3:0] PLEN_READ  = 4'd6;
    localparam logic [3:0] PLEN_WRITE = 4'd10;

    typedef struct packed {
        logic                       is_write;
        logic [PAYLOAD_MAX*8-1:0]   payload;   // byte 0 in the low bits
    } t_desc;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        logic        carry;
        c = crc_in;
        for (int i = 7; i >= 0; i--) begin
            carry = c[15];
            c = {c[14:0], data[i]};
            if (carry) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/oafb_front.sv
// Front end: configuration registers and command capture into a frame descriptor
`timescale 1ns / 1ps
`default_nettype none
module oafb_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [7:0]         i_cfg_data,
    input  wire logic               i_start,
    input  wire logic               i_mode,
    input  wire logic [15:0]        i_object_index,
    input  wire logic [31:0]        i_write_value,
    input  wire oafb_pkg::t_q_stat  i_q_stat,
    output logic                    o_busy,
    output logic                    o_push,
    output oafb_pkg::t_desc         o_desc
);

    logic [7:0] r_node_id;
    logic [7:0] r_sub_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id   <= oafb_pkg::NODE_ID_RESET;
            r_sub_index <= oafb_pkg::SUB_INDEX_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                oafb_pkg::REG_NODE_ID:   r_node_id   <= i_cfg_data;
                oafb_pkg::REG_SUB_INDEX: r_sub_index <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [7:0]  w_op;
    logic [7:0]  w_len;
    logic [31:0] w_val;

    always_comb begin
        w_op  = i_mode ? oafb_pkg::OP_WRITE  : oafb_pkg::OP_READ;
        w_len = i_mode ? oafb_pkg::LEN_WRITE : oafb_pkg::LEN_READ;
        w_val = i_mode ? i_write_value : 32'd0;
        o_busy  = i_q_stat.full;
        o_push  = i_start && !i_q_stat.full;
        o_desc.is_write = i_mode;
        o_desc.payload  = {w_val, r_sub_index, i_object_index, r_node_id, w_len, w_op};
    end

endmodule
`default_nettype wire

### hw/rtl/oafb_fifo.sv
// Short descriptor queue between the front end and the byte sequencer
`timescale 1ns / 1ps
`default_nettype none
module oafb_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire oafb_pkg::t_desc    i_desc,
    input  wire logic               i_pop,
    output oafb_pkg::t_desc         o_desc,
    output oafb_pkg::t_q_stat       o_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    oafb_pkg::t_desc  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;

    logic w_push;
    logic w_pop;

    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign w_push = i_push && !o_stat.full;
    assign w_pop  = i_pop && !o_stat.empty;
    assign o_desc = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

### hw/rtl/oafb_back.sv
// Back end: emits frame bytes one per cycle and runs the CRC a byte per cycle
`timescale 1ns / 1ps
`default_nettype none
module oafb_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire oafb_pkg::t_desc    i_desc,
    input  wire oafb_pkg::t_q_stat  i_q_stat,
    output logic                    o_pop,
    output logic                    o_valid,
    output logic [7:0]              o_frame_byte,
    output logic                    o_last_byte
);

    localparam int PAYLOAD_W = oafb_pkg::PAYLOAD_MAX * 8;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } t_state;

    t_state           r_state;
    oafb_pkg::t_desc  r_desc;
    logic [3:0]       r_pos;
    logic [15:0]      r_crc;
    logic             r_valid;
    logic [7:0]       r_byte;
    logic             r_last;

    logic [3:0]  w_plen;
    logic [3:0]  w_bidx;
    logic [3:0]  w_fidx;
    logic [PAYLOAD_W-1:0] w_sh_out;
    logic [PAYLOAD_W-1:0] w_sh_feed;
    logic [7:0]  w_out_byte;
    logic [7:0]  w_feed_byte;
    logic        w_is_last;
    logic        w_feed_en;
    logic [15:0] n_crc;

    always_comb begin
        w_plen    = r_desc.is_write ? oafb_pkg::PLEN_WRITE : oafb_pkg::PLEN_READ;
        w_bidx    = r_pos - 4'd2;
        // payload words are little endian but the CRC takes them MSB first
        w_fidx    = r_pos ^ 4'd1;
        w_sh_out  = r_desc.payload >> {w_bidx, 3'b000};
        w_sh_feed = r_desc.payload >> {w_fidx, 3'b000};
        w_is_last = (r_pos == w_plen + 4'd3);
        w_feed_en = (r_pos < w_plen + 4'd2);
        w_feed_byte = (r_pos < w_plen) ? w_sh_feed[7:0] : 8'd0;
        n_crc = oafb_pkg::crc_byte(r_crc, w_feed_byte);
        priority if (r_pos == 4'd0) begin
            w_out_byte = oafb_pkg::MARK_DLE;
        end else if (r_pos == 4'd1) begin
            w_out_byte = oafb_pkg::MARK_STX;
        end else if (r_pos == w_plen + 4'd2) begin
            w_out_byte = r_crc[7:0];
        end else if (r_pos == w_plen + 4'd3) begin
            w_out_byte = r_crc[15:8];
        end else begin
            w_out_byte = w_sh_out[7:0];
        end
        o_pop = !i_q_stat.empty && ((r_state == ST_IDLE) || w_is_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
            r_pos   <= '0;
            r_crc   <= '0;
        end else begin
            r_valid <= 1'b0;
            r_last  <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_desc  <= i_desc;
                        r_pos   <= '0;
                        r_crc   <= '0;
                        r_state <= ST_SEND;
                    end
                end
                ST_SEND: begin
                    r_valid <= 1'b1;
                    r_byte  <= w_out_byte;
                    r_last  <= w_is_last;
                    r_pos   <= r_pos + 4'd1;
                    if (w_feed_en) begin
                        r_crc <= n_crc;
                    end
                    if (w_is_last) begin
                        if (o_pop) begin
                            r_desc <= i_desc;
                            r_pos  <= '0;
                            r_crc  <= '0;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid      = r_valid;
    assign o_frame_byte = r_byte;
    assign o_last_byte  = r_last;

endmodule
`default_nettype wire

### hw/rtl/object_access_frame_builder.sv
// Top level: serial command frame builder for motor controller object access
//
//  channel   direction  handshake             payload
//  command   in         start && !busy        i_mode, i_object_index, i_write_value
//  frame     out        o_valid (one cycle)   o_frame_byte, o_last_byte
//  config    in         i_cfg_we              i_cfg_idx, i_cfg_data
//
// A read frame is 10 bytes and a write frame 14; the back-end sequencer sends one
// byte per cycle. With the sequencer idle, an accepted command passes the queue,
// the descriptor register and the output byte register before its first byte appears.
// The command queue holds QUEUE_DEPTH frames; busy is high while it is full.
// Synchronous active-low reset: queue empty, node id 1, subindex 0.
// The receiver cannot stall; every byte beat is taken when shown.
`timescale 1ns / 1ps
`default_nettype none
module object_access_frame_builder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_mode,
    input  wire logic [15:0] i_object_index,
    input  wire logic [31:0] i_write_value,
    output logic             o_valid,
    output logic [7:0]       o_frame_byte,
    output logic             o_last_byte
);

    oafb_pkg::t_desc   w_push_desc;
    oafb_pkg::t_desc   w_head_desc;
    oafb_pkg::t_q_stat w_q_stat;
    logic              w_push;
    logic              w_pop;

    oafb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_start        (start),
        .i_mode         (i_mode),
        .i_object_index (i_object_index),
        .i_write_value  (i_write_value),
        .i_q_stat       (w_q_stat),
        .o_busy         (busy),
        .o_push         (w_push),
        .o_desc         (w_push_desc)
    );

    oafb_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_push_desc),
        .i_pop   (w_pop),
        .o_desc  (w_head_desc),
        .o_stat  (w_q_stat)
    );

    oafb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc       (w_head_desc),
        .i_q_stat     (w_q_stat),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .o_frame_byte (o_frame_byte),
        .o_last_byte  (o_last_byte)
    );

endmodule
`default_nettype wire

### hw/rtl/oafb_checker.sv
// Port-level checker for the frame builder and its bind
`timescale 1ns / 1ps
`default_nettype none
module oafb_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic [7:0] i_frame_byte,
    input wire logic       i_last_byte
);

    a_last_is_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_last_byte |-> i_valid)
        else $error("last_byte without a byte beat");

    a_frame_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_valid) |-> i_frame_byte == oafb_pkg::MARK_DLE)
        else $error("frame does not open with the DLE mark");

    a_stx_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_valid) |=> i_valid && i_frame_byte == oafb_pkg::MARK_STX)
        else $error("STX mark missing after DLE");

    a_opcode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_valid) |-> ##2 (i_valid && (i_frame_byte == oafb_pkg::OP_READ
                                         || i_frame_byte == oafb_pkg::OP_WRITE)))
        else $error("bad opcode byte");

    a_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_last_byte |=> !i_valid || i_frame_byte == oafb_pkg::MARK_DLE)
        else $error("next frame does not open with the DLE mark");

endmodule

bind object_access_frame_builder oafb_checker u_oafb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_valid),
    .i_frame_byte (o_frame_byte),
    .i_last_byte  (o_last_byte)
);
`default_nettype wire
